>>> hdl/uaft_pkg.sv
// Shared types, constants and the code point fold function for the UTF-8 fold/trim unit.
// No dependencies; used by uaft_ctrl, uaft_datapath and the top level.
`timescale 1ns / 1ps

package uaft_pkg;

    // saturation bound of the held space run
    localparam int SPACE_W = 6;
    localparam logic [SPACE_W-1:0] MAX_SPACE_RUN = 6'd60;

    // up to four code points come out of one byte (flushed sequence plus the byte itself)
    localparam int SLOT_N     = 4;
    localparam int SLOT_IDX_W = 2;
    localparam int SLOT_CNT_W = 3;

    localparam int CP_W = 21;

    // fold classes
    localparam logic [1:0] KIND_DROP  = 2'd0;
    localparam logic [1:0] KIND_SPACE = 2'd1;
    localparam logic [1:0] KIND_CHAR  = 2'd2;

    typedef struct packed {
        logic [1:0] kind;
        logic [6:0] ch;
    } fold_t;

    typedef struct packed {
        logic capture;
        logic advance;
        logic count_space;
        logic emit_space;
        logic emit_char;
        logic emit_marker;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic       done;
        logic       last_slot;
        logic [1:0] cur_kind;
        logic       pend_nz;
        logic       is_end;
        logic       emitted;
        logic       out_free;
    } status_t;

    function automatic fold_t fold_cp(input logic [CP_W-1:0] cp);
        fold_t f;
        f.kind = KIND_CHAR;
        f.ch   = 7'd0;
        if (cp < 21'h80) begin
            f.ch = cp[6:0];
            if (cp[6:0] == 7'h20)
                f.kind = KIND_SPACE;
        end
        else if (cp >= 21'h300 && cp <= 21'h36F)
            f.kind = KIND_DROP;
        else if (cp == 21'h2018 || cp == 21'h2019 || cp == 21'h2032)
            f.ch = 7'h27;
        else if (cp == 21'h201C || cp == 21'h201D || cp == 21'h2033)
            f.ch = 7'h22;
        else if (cp == 21'h2013 || cp == 21'h2014)
            f.ch = 7'h2D;
        else if (cp == 21'h00A0) begin
            f.kind = KIND_SPACE;
            f.ch   = 7'h20;
        end
        else if (cp == 21'h00AD || cp == 21'h0131)
            f.ch = 7'h69;
        else if ((cp >= 21'hC0 && cp <= 21'hC5) || (cp >= 21'hE0 && cp <= 21'hE5))
            f.ch = 7'h61;
        else if ((cp >= 21'hC8 && cp <= 21'hCB) || (cp >= 21'hE8 && cp <= 21'hEB))
            f.ch = 7'h65;
        else if ((cp >= 21'hCC && cp <= 21'hCF) || (cp >= 21'hEC && cp <= 21'hEF))
            f.ch = 7'h69;
        else if ((cp >= 21'hD2 && cp <= 21'hD6) || (cp >= 21'hF2 && cp <= 21'hF6))
            f.ch = 7'h6F;
        else if ((cp >= 21'hD9 && cp <= 21'hDC) || (cp >= 21'hF9 && cp <= 21'hFC))
            f.ch = 7'h75;
        else if (cp == 21'hD1 || cp == 21'hF1)
            f.ch = 7'h6E;
        else if (cp == 21'hC7 || cp == 21'hE7)
            f.ch = 7'h63;
        else
            f.kind = KIND_DROP;
        return f;
    endfunction

endpackage

>>> hdl/uaft_ctrl.sv
// Sequencer for the UTF-8 fold/trim unit: accepts a byte, then walks its code point slots.
// Depends on uaft_pkg.
`timescale 1ns / 1ps

module uaft_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  uaft_pkg::status_t st,
    output uaft_pkg::cmd_t    cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_WALK = 1'b1;

    logic state_reg;
    logic state_next;
    logic need_marker;

    assign s_tready    = (state_reg == ST_IDLE);
    assign need_marker = st.is_end && !st.emitted;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (st.done)
                begin
                    if (need_marker)
                    begin
                        if (st.out_free)
                        begin
                            cmd.emit_marker = 1'b1;
                            cmd.finish      = 1'b1;
                            state_next      = ST_IDLE;
                        end
                    end
                    else
                    begin
                        cmd.finish = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    case (st.cur_kind)
                        uaft_pkg::KIND_CHAR:
                        begin
                            if (st.out_free)
                            begin
                                // held spaces go out ahead of the character
                                if (st.pend_nz)
                                    cmd.emit_space = 1'b1;
                                else
                                begin
                                    cmd.emit_char = 1'b1;
                                    cmd.advance   = 1'b1;
                                    if (st.last_slot)
                                    begin
                                        cmd.finish = 1'b1;
                                        state_next = ST_IDLE;
                                    end
                                end
                            end
                        end
                        uaft_pkg::KIND_SPACE:
                        begin
                            cmd.count_space = 1'b1;
                            cmd.advance     = 1'b1;
                            if (st.last_slot && !need_marker)
                            begin
                                cmd.finish = 1'b1;
                                state_next = ST_IDLE;
                            end
                        end
                        default:
                        begin
                            cmd.advance = 1'b1;
                            if (st.last_slot && !need_marker)
                            begin
                                cmd.finish = 1'b1;
                                state_next = ST_IDLE;
                            end
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

>>> hdl/uaft_datapath.sv
// Datapath of the UTF-8 fold/trim unit: decoder state, slot list, space run and output beat.
// Depends on uaft_pkg.
`timescale 1ns / 1ps

module uaft_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [7:0]        s_tdata,   // [7:0] in_byte
    input  logic              s_tlast,
    input  uaft_pkg::cmd_t    cmd,
    output uaft_pkg::status_t st,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,   // [6:0] out_char, [7] zero
    output logic              m_tuser,   // [0] char_valid
    output logic              m_tlast
);

    // decoder state
    logic [7:0] lead_reg, lead_next;
    logic [7:0] held_reg [2];
    logic [1:0] need_reg, need_next;
    logic [1:0] hcnt_reg, hcnt_next;

    // text state
    logic                         started_reg;
    logic [uaft_pkg::SPACE_W-1:0] pend_reg;

    // per-byte slot list
    logic                            end_reg;
    logic                            emitted_reg;
    logic [uaft_pkg::SLOT_CNT_W-1:0] cnt_reg, cnt_next;
    logic [uaft_pkg::SLOT_CNT_W-1:0] idx_reg;
    logic [1:0]                      kind_reg [uaft_pkg::SLOT_N];
    logic [6:0]                      ch_reg   [uaft_pkg::SLOT_N];

    logic [uaft_pkg::CP_W-1:0] slot_cp [uaft_pkg::SLOT_N];
    uaft_pkg::fold_t           slot_fold [uaft_pkg::SLOT_N];

    // output beat
    logic       out_valid_reg;
    logic [6:0] out_ch_reg;
    logic       out_cv_reg;
    logic       out_last_reg;

    logic                            is_cont;
    logic [1:0]                      fresh_need;
    logic                            fresh_open;
    logic                            flushing;
    logic [uaft_pkg::CP_W-1:0]       joined_cp;
    logic [uaft_pkg::SLOT_IDX_W-1:0] cur;
    logic                            later_char;
    logic                            out_free;
    logic                            store_held;

    assign is_cont = (s_tdata[7:6] == 2'b10);

    always_comb
    begin
        if (s_tdata[7:5] == 3'b110)
            fresh_need = 2'd1;
        else if (s_tdata[7:4] == 4'b1110)
            fresh_need = 2'd2;
        else if (s_tdata[7:3] == 5'b11110)
            fresh_need = 2'd3;
        else
            fresh_need = 2'd0;
    end

    assign fresh_open = (fresh_need != 2'd0) && !s_tlast;

    always_comb
    begin
        case (hcnt_reg)
            2'd0:    joined_cp = {10'd0, lead_reg[4:0], s_tdata[5:0]};
            2'd1:    joined_cp = {5'd0, lead_reg[3:0], held_reg[0][5:0], s_tdata[5:0]};
            default: joined_cp = {lead_reg[2:0], held_reg[0][5:0], held_reg[1][5:0],
                                  s_tdata[5:0]};
        endcase
    end

    // slot list and next decoder state for the byte on the input
    always_comb
    begin
        lead_next  = lead_reg;
        need_next  = need_reg;
        hcnt_next  = hcnt_reg;
        cnt_next   = '0;
        flushing   = 1'b0;
        store_held = 1'b0;
        if (need_reg == 2'd0)
        begin
            if (fresh_open)
            begin
                lead_next = s_tdata;
                need_next = fresh_need;
                hcnt_next = 2'd0;
            end
            else
                cnt_next = 3'd1;
        end
        else if (is_cont)
        begin
            if (need_reg == 2'd1)
            begin
                cnt_next  = 3'd1;
                need_next = 2'd0;
                hcnt_next = 2'd0;
            end
            else
            begin
                store_held = 1'b1;
                hcnt_next  = hcnt_reg + 2'd1;
                need_next  = need_reg - 2'd1;
                if (s_tlast)
                begin
                    flushing = 1'b1;
                    cnt_next = {1'b0, hcnt_reg} + 3'd2;
                end
            end
        end
        else
        begin
            // broken sequence: lead and held bytes, then the byte afresh
            flushing = 1'b1;
            if (fresh_open)
            begin
                cnt_next  = {1'b0, hcnt_reg} + 3'd1;
                lead_next = s_tdata;
                need_next = fresh_need;
                hcnt_next = 2'd0;
            end
            else
            begin
                cnt_next  = {1'b0, hcnt_reg} + 3'd2;
                need_next = 2'd0;
                hcnt_next = 2'd0;
            end
        end
        if (s_tlast)
        begin
            lead_next = 8'd0;
            need_next = 2'd0;
            hcnt_next = 2'd0;
        end
    end

    always_comb
    begin
        for (int i = 0; i < uaft_pkg::SLOT_N; i++)
        begin
            if (flushing)
            begin
                if (i == 0)
                    slot_cp[i] = {13'd0, lead_reg};
                else if ((i - 1) < int'(hcnt_reg))
                    slot_cp[i] = {13'd0, held_reg[1'(i + 1)]};
                else
                    slot_cp[i] = {13'd0, s_tdata};
            end
            else if (need_reg != 2'd0)
                slot_cp[i] = joined_cp;
            else
                slot_cp[i] = {13'd0, s_tdata};
            slot_fold[i] = uaft_pkg::fold_cp(slot_cp[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lead_reg <= 8'd0;
            need_reg <= 2'd0;
            hcnt_reg <= 2'd0;
            cnt_reg  <= '0;
            end_reg  <= 1'b0;
        end
        else if (cmd.capture)
        begin
            lead_reg <= lead_next;
            need_reg <= need_next;
            hcnt_reg <= hcnt_next;
            cnt_reg  <= cnt_next;
            end_reg  <= s_tlast;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            if (store_held)
                held_reg[hcnt_reg[0]] <= s_tdata;
            for (int i = 0; i < uaft_pkg::SLOT_N; i++)
            begin
                kind_reg[i] <= slot_fold[i].kind;
                ch_reg[i]   <= slot_fold[i].ch;
            end
        end
    end

    // slot walk
    assign cur = idx_reg[uaft_pkg::SLOT_IDX_W-1:0];

    always_comb
    begin
        later_char = 1'b0;
        for (int j = 0; j < uaft_pkg::SLOT_N; j++)
        begin
            if (uaft_pkg::SLOT_CNT_W'(j) > idx_reg && uaft_pkg::SLOT_CNT_W'(j) < cnt_reg
                && kind_reg[j] == uaft_pkg::KIND_CHAR)
                later_char = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg     <= '0;
            emitted_reg <= 1'b0;
        end
        else
        begin
            if (cmd.capture)
                idx_reg <= '0;
            else if (cmd.advance)
                idx_reg <= idx_reg + 3'd1;
            if (cmd.capture)
                emitted_reg <= 1'b0;
            else if (cmd.emit_space || cmd.emit_char || cmd.emit_marker)
                emitted_reg <= 1'b1;
        end
    end

    // space run and text start
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg <= 1'b0;
            pend_reg    <= '0;
        end
        else if (cmd.finish && end_reg)
        begin
            started_reg <= 1'b0;
            pend_reg    <= '0;
        end
        else
        begin
            if (cmd.emit_char)
                started_reg <= 1'b1;
            if (cmd.emit_space)
                pend_reg <= pend_reg - 6'd1;
            else if (cmd.count_space && started_reg && pend_reg < uaft_pkg::MAX_SPACE_RUN)
                pend_reg <= pend_reg + 6'd1;
        end
    end

    // output beat register
    assign out_free = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit_space || cmd.emit_char || cmd.emit_marker)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_space)
        begin
            out_ch_reg   <= 7'h20;
            out_cv_reg   <= 1'b1;
            out_last_reg <= 1'b0;
        end
        else if (cmd.emit_char)
        begin
            out_ch_reg   <= ch_reg[cur];
            out_cv_reg   <= 1'b1;
            out_last_reg <= end_reg && !later_char;
        end
        else if (cmd.emit_marker)
        begin
            out_ch_reg   <= 7'd0;
            out_cv_reg   <= 1'b0;
            out_last_reg <= 1'b1;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_ch_reg};
    assign m_tuser  = out_cv_reg;
    assign m_tlast  = out_last_reg;

    assign st.done      = (idx_reg == cnt_reg);
    assign st.last_slot = ((idx_reg + 3'd1) == cnt_reg);
    assign st.cur_kind  = kind_reg[cur];
    assign st.pend_nz   = (pend_reg != '0);
    assign st.is_end    = end_reg;
    assign st.emitted   = emitted_reg;
    assign st.out_free  = out_free;

    a_one_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.emit_space, cmd.emit_char, cmd.emit_marker}))
        else $error("more than one result loaded in a cycle");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_space || cmd.emit_char || cmd.emit_marker) |-> out_free)
        else $error("result loaded over an unsent beat");

    a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= uaft_pkg::MAX_SPACE_RUN)
        else $error("space run above bound");

    a_marker_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> m_tlast)
        else $error("end marker without last");

    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= cnt_reg)
        else $error("slot walk ran past the list");

endmodule

>>> hdl/utf8_ascii_fold_trim_unit.sv
// Top level of the UTF-8 to trimmed ASCII fold unit.
// Depends on uaft_pkg, uaft_ctrl and uaft_datapath.
`timescale 1ns / 1ps

// Takes one UTF-8 byte per input beat (tlast on the final byte of the string) and gives folded
// ASCII characters on the output, one per beat, tuser high when tdata carries a character.
// A byte is taken while the sequencer is idle; the block then walks the code points decoded from it (one
// for a plain byte, up to four when a broken sequence is replayed) and sends any held spaces
// ahead of a character before the character itself. A string end that produced no character
// also gets an end marker beat. The output register lets the next byte be taken while a
// result still waits on tready; a stalled output holds the slot walk.
module utf8_ascii_fold_trim_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,   // end_of_string
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [6:0] out_char, [7] zero
    output logic       m_tuser,   // [0] char_valid
    output logic       m_tlast    // last
);

    uaft_pkg::cmd_t    cmd;
    uaft_pkg::status_t st;

    uaft_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    uaft_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .cmd      (cmd),
        .st       (st),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

>>> tb/utf8_ascii_fold_trim_unit_tb.sv
// Self-checking testbench for utf8_ascii_fold_trim_unit: directed strings, then random UTF-8 text.
// Depends on uaft_pkg (space run bound) and the unit's RTL; a built-in fold predictor
// checks each beat.
`timescale 1ns / 1ps

module utf8_ascii_fold_trim_unit_tb;

    localparam int IDLE_LIMIT   = 3000;
    localparam int RANDOM_ITEMS = 344;
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_AFTER   = 120;
    localparam int RESULT_CAP   = 64;
    localparam int END_SETTLE   = 20;
    localparam logic [6:0] ASCII_SPACE = 7'h20;

    typedef struct packed {
        logic [6:0] ch;
        logic       valid;
        logic       last;
    } ascii_beat_t;

    typedef struct packed {
        logic [7:0] b;
        logic       eos;
        logic       typed;
        logic [6:0] ch;
        logic       valid;
        logic       last;
    } dir_row_t;

    logic       clk;
    logic       rst_n    = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;
    logic       s_tlast  = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tuser;
    logic       m_tlast;

    // sidecar of the beat on the input bus: a typed-in expectation replaces the predicted one
    logic        row_typed = 1'b0;
    ascii_beat_t row_want  = '0;

    int send_idle_pct = 19;
    int recv_idle_pct = 56;
    int hold_left     = 0;
    bit held_off      = 1'b0;
    int results_seen  = 0;
    int idle_cycles   = 0;
    int errors        = 0;

    ascii_beat_t expected_chars[$];
    logic [7:0]  str_bytes[$];
    logic [7:0]  punct_tails[8] = '{8'h93, 8'h94, 8'h98, 8'h99, 8'h9C, 8'h9D, 8'hB2, 8'hB3};

    // b, eos, typed, ch, valid, last
    dir_row_t directed_rows[26] = '{
        '{8'h20, 1'b1, 1'b1, 7'h00, 1'b0, 1'b1},  // lone leading space: end marker only
        '{8'h00, 1'b1, 1'b1, 7'h00, 1'b1, 1'b1},  // character 0 is real text
        '{8'h7F, 1'b1, 1'b1, 7'h7F, 1'b1, 1'b1},
        '{8'hFF, 1'b1, 1'b1, 7'h00, 1'b0, 1'b1},  // stray high byte folds to nothing
        '{8'h41, 1'b0, 1'b1, 7'h41, 1'b1, 1'b0},
        '{8'h20, 1'b0, 1'b0, 7'h00, 1'b0, 1'b0},
        '{8'hC2, 1'b0, 1'b0, 7'h00, 1'b0, 1'b0},  // NBSP
        '{8'hA0, 1'b0, 1'b0, 7'h00, 1'b0, 1'b0},
        '{8'hE2, 1'b0, 1'b0, 7'h00, 1'b0, 1'b0},  // em dash after two held spaces
        '{8'h80, 1'b0, 1'b0, 7'h00, 1'b0, 1'b0},
        '{8'h94, 1'b0, 1'b0, 7'h00, 1'b0, 1'b0},
        '{8'hCC, 1'b0, 1'b0, 7'h00, 1'b0, 1'b0},  // combining acute, dropped
        '{8'h81, 1'b0, 1'b0, 7'h00, 1'b0, 1'b0},
        '{8'hF0, 1'b0, 1'b0, 7'h00, 1'b0, 1'b0},  // 4-byte emoji, dropped
        '{8'h9F, 1'b0, 1'b0, 7'h00, 1'b0, 1'b0},
        '{8'h98, 1'b0, 1'b0, 7'h00, 1'b0, 1'b0},
        '{8'h80, 1'b0, 1'b0, 7'h00, 1'b0, 1'b0},
        '{8'hC3, 1'b0, 1'b0, 7'h00, 1'b0, 1'b0},  // broken right after the lead
        '{8'h41, 1'b0, 1'b0, 7'h00, 1'b0, 1'b0},
        '{8'hE2, 1'b0, 1'b0, 7'h00, 1'b0, 1'b0},  // broken with one continuation held
        '{8'h80, 1'b0, 1'b0, 7'h00, 1'b0, 1'b0},
        '{8'h20, 1'b0, 1'b0, 7'h00, 1'b0, 1'b0},
        '{8'hC0, 1'b0, 1'b0, 7'h00, 1'b0, 1'b0},  // overlong NUL
        '{8'h80, 1'b0, 1'b0, 7'h00, 1'b0, 1'b0},
        '{8'hE9, 1'b0, 1'b0, 7'h00, 1'b0, 1'b0},  // cut off by the end of string
        '{8'hBF, 1'b1, 1'b0, 7'h00, 1'b0, 1'b0}
    };

    // fold predictor state
    logic [7:0]  seq_lead = 8'h00;
    logic [7:0]  seq_cont[2];
    int unsigned seq_need  = 0;
    int unsigned seq_held  = 0;
    bit          text_seen = 1'b0;
    int unsigned space_run = 0;
    int          step_base = 0;

    utf8_ascii_fold_trim_unit u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function void add_byte(input logic [7:0] b);
        str_bytes.insert(str_bytes.size(), b);
    endfunction

    function void queue_beat(input ascii_beat_t beat);
        expected_chars.insert(expected_chars.size(), beat);
    endfunction

    // -1 means the code point is dropped
    function automatic int fold_code_point(input int unsigned cp);
        if (cp < 'h80)
            return int'(cp);
        if (cp >= 'h300 && cp <= 'h36F)
            return -1;
        if (cp == 'h2018 || cp == 'h2019 || cp == 'h2032)
            return 'h27;
        if (cp == 'h201C || cp == 'h201D || cp == 'h2033)
            return 'h22;
        if (cp == 'h2013 || cp == 'h2014)
            return 'h2D;
        if (cp == 'hA0)
            return 'h20;
        if (cp == 'hAD || cp == 'h131)
            return "i";
        if ((cp >= 'hC0 && cp <= 'hC5) || (cp >= 'hE0 && cp <= 'hE5))
            return "a";
        if ((cp >= 'hC8 && cp <= 'hCB) || (cp >= 'hE8 && cp <= 'hEB))
            return "e";
        if ((cp >= 'hCC && cp <= 'hCF) || (cp >= 'hEC && cp <= 'hEF))
            return "i";
        if ((cp >= 'hD2 && cp <= 'hD6) || (cp >= 'hF2 && cp <= 'hF6))
            return "o";
        if ((cp >= 'hD9 && cp <= 'hDC) || (cp >= 'hF9 && cp <= 'hFC))
            return "u";
        if (cp == 'hD1 || cp == 'hF1)
            return "n";
        if (cp == 'hC7 || cp == 'hE7)
            return "c";
        return -1;
    endfunction

    function void push_char(input logic [6:0] c, input logic v);
        if (expected_chars.size() - step_base < RESULT_CAP)
            queue_beat({c, v, 1'b0});
    endfunction

    function void put_code_point(input int unsigned cp);
        int ch;
        ch = fold_code_point(cp);
        if (ch < 0)
            return;
        if (ch == 'h20)
        begin
            if (text_seen && space_run < uaft_pkg::MAX_SPACE_RUN)
                space_run++;
            return;
        end
        while (space_run > 0)
        begin
            push_char(ASCII_SPACE, 1'b1);
            space_run--;
        end
        push_char(ch[6:0], 1'b1);
        text_seen = 1'b1;
    endfunction

    // broken or cut-off sequence: lead and held bytes fold as plain byte values
    function void replay_open_seq();
        put_code_point(seq_lead);
        for (int k = 0; k < seq_held && k < 2; k++)
            put_code_point(seq_cont[k]);
        seq_need = 0;
        seq_held = 0;
    endfunction

    function void open_byte(input logic [7:0] b, input logic eos);
        int unsigned need;
        need = 0;
        if (b < 8'h80)
        begin
            put_code_point(b);
            return;
        end
        if ((b & 8'hE0) == 8'hC0)
            need = 1;
        else if ((b & 8'hF0) == 8'hE0)
            need = 2;
        else if ((b & 8'hF8) == 8'hF0)
            need = 3;
        if (need == 0 || eos)
        begin
            put_code_point(b);
            return;
        end
        seq_lead = b;
        seq_need = need;
        seq_held = 0;
    endfunction

    function void fold_step(input logic [7:0] b, input logic eos);
        int unsigned cp;
        ascii_beat_t tail;
        step_base = expected_chars.size();
        if (seq_need == 0)
            open_byte(b, eos);
        else if (b[7:6] == 2'b10)
        begin
            if (seq_need == 1)
            begin
                case (seq_held)
                    0:       cp = {seq_lead[4:0], b[5:0]};
                    1:       cp = {seq_lead[3:0], seq_cont[0][5:0], b[5:0]};
                    default: cp = {seq_lead[2:0], seq_cont[0][5:0], seq_cont[1][5:0], b[5:0]};
                endcase
                seq_need = 0;
                seq_held = 0;
                put_code_point(cp);
            end
            else
            begin
                if (seq_held < 2)
                begin
                    seq_cont[seq_held] = b;
                    seq_held++;
                end
                seq_need--;
                if (eos)
                    replay_open_seq();
            end
        end
        else
        begin
            replay_open_seq();
            open_byte(b, eos);
        end
        if (eos)
        begin
            if (expected_chars.size() == step_base)
                push_char(7'h00, 1'b0);
            tail = expected_chars.pop_back();
            tail.last = 1'b1;
            queue_beat(tail);
            seq_lead  = 8'h00;
            seq_need  = 0;
            seq_held  = 0;
            text_seen = 1'b0;
            space_run = 0;
        end
    endfunction

    function automatic logic [7:0] lead_for(input int need);
        case (need)
            1:       return 8'hC0 + 8'($urandom_range(0, 31));
            2:       return 8'hE0 + 8'($urandom_range(0, 15));
            default: return 8'hF0 + 8'($urandom_range(0, 7));
        endcase
    endfunction

    function void add_seq(input logic [7:0] lead, input int nconts);
        add_byte(lead);
        repeat (nconts)
            add_byte({2'b10, 6'($urandom)});
    endfunction

    // mostly well-formed text with random content, some broken and stray bytes
    function void build_random_string();
        int pick;
        int n;
        str_bytes.delete();
        repeat ($urandom_range(1, 12))
        begin
            pick = $urandom_range(0, 99);
            if (pick < 30)
                add_byte(($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 127))
                                                     : 8'($urandom_range(33, 126)));
            else if (pick < 42)
            begin
                n = ($urandom_range(0, 14) == 0) ? $urandom_range(55, 70) : $urandom_range(1, 4);
                repeat (n)
                begin
                    if ($urandom_range(0, 5) == 0)
                    begin
                        add_byte(8'hC2);
                        add_byte(8'hA0);
                    end
                    else
                        add_byte(8'h20);
                end
            end
            else if (pick < 62)
            begin
                case ($urandom_range(0, 5))
                    0, 1: add_seq(8'hC3, 1);
                    2:
                    begin
                        add_byte(8'hC2);
                        add_byte($urandom_range(0, 1) ? 8'hA0 : 8'hAD);
                    end
                    3:
                    begin
                        add_byte(8'hC4);
                        add_byte(8'hB1);
                    end
                    4:       add_seq(8'hCC + 8'($urandom_range(0, 1)), 1);
                    default: add_seq(lead_for(1), 1);
                endcase
            end
            else if (pick < 75)
            begin
                if ($urandom_range(0, 1))
                begin
                    add_byte(8'hE2);
                    add_byte(8'h80);
                    add_byte(punct_tails[$urandom_range(0, 7)]);
                end
                else
                    add_seq(lead_for(2), 2);
            end
            else if (pick < 80)
                add_seq(lead_for(3), 3);
            else if (pick < 88)
            begin
                n = $urandom_range(1, 3);
                add_seq(lead_for(n), $urandom_range(0, n - 1));
                add_byte($urandom_range(0, 1) ? 8'($urandom_range(0, 127))
                                              : 8'($urandom_range(192, 255)));
            end
            else if (pick < 94)
                add_byte($urandom_range(0, 1) ? 8'($urandom_range(128, 191))
                                              : 8'($urandom_range(248, 255)));
            else
                add_byte(8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 5) == 0)
        begin
            n = $urandom_range(1, 3);
            add_seq(lead_for(n), $urandom_range(0, n - 1));
        end
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic eos, input logic typed,
                             input ascii_beat_t want);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid  <= 1'b1;
        s_tdata   <= b;
        s_tlast   <= eos;
        row_typed <= typed;
        row_want  <= want;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // receiver: random stalls plus one long hold-off so the unit backs up into its input
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (!held_off && results_seen >= HOLD_AFTER)
        begin
            m_tready  <= 1'b0;
            hold_left <= HOLD_CYCLES;
            held_off  <= 1'b1;
        end
        else
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin : watch_beats
        ascii_beat_t want;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                fold_step(s_tdata, s_tlast);
                if (row_typed)
                begin
                    while (expected_chars.size() > step_base)
                        void'(expected_chars.pop_back());
                    queue_beat(row_want);
                end
            end
            if (m_tvalid && m_tready)
            begin
                results_seen <= results_seen + 1;
                if (expected_chars.size() == 0)
                begin
                    $error("unexpected beat: out_char %h char_valid %b last %b",
                           m_tdata[6:0], m_tuser, m_tlast);
                    errors++;
                end
                else
                begin
                    want = expected_chars.pop_front();
                    if (m_tdata[6:0] !== want.ch)
                    begin
                        $error("out_char: expected %h, got %h", want.ch, m_tdata[6:0]);
                        errors++;
                    end
                    if (m_tuser !== want.valid)
                    begin
                        $error("char_valid: expected %b, got %b", want.valid, m_tuser);
                        errors++;
                    end
                    if (m_tlast !== want.last)
                    begin
                        $error("last: expected %b, got %b", want.last, m_tlast);
                        errors++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin : run_strings
        int sent;
        sent = 0;
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_byte(directed_rows[i].b, directed_rows[i].eos, directed_rows[i].typed,
                      {directed_rows[i].ch, directed_rows[i].valid, directed_rows[i].last});

        while (sent < RANDOM_ITEMS)
        begin
            if (sent >= 2 * RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 0;
                recv_idle_pct <= 0;
            end
            else if (sent >= RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 56;
                recv_idle_pct <= 19;
            end
            if (sent == 0)
            begin
                // inner space run longer than the saturation bound
                str_bytes.delete();
                add_byte("x");
                repeat (64)
                    add_byte(8'h20);
                add_byte("y");
            end
            else
                build_random_string();
            foreach (str_bytes[i])
                send_byte(str_bytes[i], i == str_bytes.size() - 1, 1'b0, '0);
            sent += str_bytes.size();
        end
        s_tvalid <= 1'b0;

        while (expected_chars.size() != 0)
            @(posedge clk);
        repeat (END_SETTLE)
            @(posedge clk);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
